// ===== sv/led_animation_state_machine_macros.svh =====
// ----------------------------------------------------------------------------
// led_animation_state_machine_macros
// assertion macros for the led animation block
// ----------------------------------------------------------------------------
`ifndef LED_ANIMATION_STATE_MACHINE_MACROS_SVH
`define LED_ANIMATION_STATE_MACHINE_MACROS_SVH
// a condition implies something in the next cycle
`define LASM_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
// a condition implies something in the same cycle
`define LASM_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`endif

// ===== sv/lasm_pkg.sv =====
// ----------------------------------------------------------------------------
// lasm_pkg
// types and constants shared by the led animation block
// ----------------------------------------------------------------------------
`default_nettype none
package lasm_pkg;

   typedef enum logic [2:0] {
      OP_FRAME     = 3'd0,
      OP_LOAD_ANIM = 3'd1,
      OP_LOAD_EXIT = 3'd2,
      OP_LOAD_ST   = 3'd3,
      OP_LOAD_LIST = 3'd4,
      OP_RESTART   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANIM,
      ST_PREFIX,
      ST_LIST,
      ST_EXIT,
      ST_TEST,
      ST_COLOUR,
      ST_OUT
   } fsm_type;

   localparam logic [1:0] REPEAT_WRAP   = 2'd1;
   localparam logic [1:0] REPEAT_BOUNCE = 2'd2;
   localparam logic [1:0] METH_BINARY = 2'd1;
   localparam logic [1:0] METH_LERP   = 2'd2;
   localparam logic [2:0] DIR_NORTH   = 3'd1;
   localparam logic [2:0] DIR_EAST    = 3'd2;
   localparam logic [2:0] DIR_SOUTH   = 3'd3;
   localparam logic [2:0] DIR_WEST    = 3'd4;
   localparam int         NEUTRAL_R2  = 25;
   localparam int         CENTRE      = 127;

   typedef struct packed {
      logic [7:0]  trigger_right;
      logic [7:0]  trigger_left;
      logic [7:0]  cstick_y;
      logic [7:0]  cstick_x;
      logic [7:0]  joy_y;
      logic [7:0]  joy_x;
      logic [15:0] buttons;
      logic [9:0]  load_extra;
      logic [63:0] load_word;
      logic [5:0]  index;
      logic [2:0]  op;
   } req_type;

   typedef struct packed {
      logic       exit_taken;
      logic [3:0] state_now;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rsp_type;

   // exit test inputs gathered for the condition checker
   typedef struct packed {
      logic [20:0] cond;
      logic [52:0] lim;
      logic [7:0]  frac;
   } exit_chk_type;

endpackage
`default_nettype wire

// ===== sv/lasm_exit_check.sv =====
// ----------------------------------------------------------------------------
// lasm_exit_check
// tests one exit entry against the controller inputs, registered result
// ----------------------------------------------------------------------------
`default_nettype none
module lasm_exit_check (
   input  wire                    clock,
   input  lasm_pkg::exit_chk_type chk,
   input  lasm_pkg::req_type      req,
   output logic                   pass_ff
);

   logic        pass_in;
   logic [6:0]  amask;
   logic [15:0] bmask;
   logic [4:0]  succ;
   logic [4:0]  need;
   logic [6:0]  hit;

   function automatic logic stick_in(input logic [2:0] dir, input logic [7:0] x,
                                     input logic [7:0] y);
      logic signed [8:0]  dx;
      logic signed [8:0]  dy;
      logic        [8:0]  ax;
      logic        [8:0]  ay;
      logic        [16:0] r2;
      logic               neu;
      dx  = $signed({1'b0, x}) - 9'sd127;
      dy  = $signed({1'b0, y}) - 9'sd127;
      ax  = dx[8] ? 9'(-dx) : 9'(dx);
      ay  = dy[8] ? 9'(-dy) : 9'(dy);
      r2  = (17'(ax) * 17'(ax)) + (17'(ay) * 17'(ay));
      neu = (r2 <= 17'(lasm_pkg::NEUTRAL_R2));
      case (dir)
         lasm_pkg::DIR_NORTH: stick_in = !neu && !dy[8] && (ax <= ay);
         lasm_pkg::DIR_EAST:  stick_in = !neu && !dx[8] && (ay < ax);
         lasm_pkg::DIR_SOUTH: stick_in = !neu && dy[8] && (ax <= ay);
         lasm_pkg::DIR_WEST:  stick_in = !neu && dx[8] && (ay < ax);
         default:             stick_in = neu;
      endcase
   endfunction

   always_comb begin
      bmask  = chk.cond[20:5];
      amask  = chk.lim[6:0];
      hit[0] = stick_in(chk.lim[9:7], req.joy_x, req.joy_y);
      hit[1] = stick_in(chk.lim[12:10], req.cstick_x, req.cstick_y);
      hit[2] = req.trigger_left > chk.lim[20:13];
      hit[3] = req.trigger_left < chk.lim[28:21];
      hit[4] = req.trigger_right > chk.lim[36:29];
      hit[5] = req.trigger_right < chk.lim[44:37];
      hit[6] = chk.frac >= chk.lim[52:45];
      succ   = 5'($countones(bmask & req.buttons)) + 5'($countones(amask & hit));
      need   = 5'($countones(bmask)) + 5'($countones(amask));
      pass_in = chk.cond[4] ? (succ != 5'd0) : (succ >= need);
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
   end

endmodule
`default_nettype wire

// ===== sv/led_animation_state_machine.sv =====
// ----------------------------------------------------------------------------
// led_animation_state_machine
// programmable led animation engine with exit driven state transitions
// ----------------------------------------------------------------------------
// usage
//   req_ carries one transaction per operation: a frame, a table load or a
//   restart. every transaction yields exactly one rsp_ transaction with the
//   colour, the current state and whether an exit was taken.
//   loads, restarts and spare ops pass from acceptance through ST_ANIM,
//   ST_COLOUR and ST_OUT to rsp_valid. a frame walks the states below the
//   current one to find its exit list start (read then add for each state),
//   then tests its exits one at a time (list read, exit read, test,
//   registered pass); the single exit checker and one-port table reads
//   keep that work serial. req_ready is low while a transaction is in
//   flight; the result is held in an output register until rsp_ready, and
//   req_ready rises again in the cycle after it is taken, so a stalled
//   receiver stalls the input too. reset clears the state index, fraction
//   and bounce direction; tables are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_animation_state_machine_macros.svh"
module led_animation_state_machine #(
   parameter int ANIM_ENTRIES      = 16,
   parameter int EXIT_ENTRIES      = 64,
   parameter int STATE_ENTRIES     = 16,
   parameter int EXIT_LIST_ENTRIES = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  lasm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output lasm_pkg::rsp_type  rsp_data
);

   localparam int AW = (ANIM_ENTRIES > 1) ? $clog2(ANIM_ENTRIES) : 1;
   localparam int EW = (EXIT_ENTRIES > 1) ? $clog2(EXIT_ENTRIES) : 1;
   localparam int SW = (STATE_ENTRIES > 1) ? $clog2(STATE_ENTRIES) : 1;
   localparam int LW = (EXIT_LIST_ENTRIES > 1) ? $clog2(EXIT_LIST_ENTRIES) : 1;

   // tables
   logic [59:0] anim_mem [ANIM_ENTRIES];
   logic [20:0] cond_mem [EXIT_ENTRIES];
   logic [52:0] lim_mem  [EXIT_ENTRIES];
   logic [9:0]  st_mem   [STATE_ENTRIES];
   logic [5:0]  list_mem [EXIT_LIST_ENTRIES];

   lasm_pkg::fsm_type fsm_ff, fsm_in;
   lasm_pkg::req_type req_ff, req_in;
   lasm_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  cur_ff, cur_in;
   logic [7:0]  frac_ff, frac_in;
   logic        down_ff, down_in;
   logic        taken_ff, taken_in;
   logic [3:0]  walk_ff, walk_in;      // state counter for the prefix sum
   logic [10:0] pos_ff, pos_in;        // exit list position
   logic [5:0]  left_ff, left_in;      // exits still to test
   logic        rd_ph_ff, rd_ph_in;    // read phase of the prefix walk

   // registered memory reads
   logic [9:0]  st_rd_ff;
   logic [59:0] anim_rd_ff;
   logic [5:0]  list_rd_ff;
   logic [20:0] cond_rd_ff;
   logic [52:0] lim_rd_ff;
   logic [SW-1:0] st_addr;
   logic [LW-1:0] list_addr;

   lasm_pkg::exit_chk_type chk;
   logic        pass;

   lasm_exit_check u_chk (
      .clock   (clock),
      .chk     (chk),
      .req     (req_ff),
      .pass_ff (pass)
   );

   assign chk = '{cond: cond_rd_ff, lim: lim_rd_ff, frac: frac_ff};

   // state table address: current state or the prefix walk counter
   always_comb begin
      if (fsm_ff == lasm_pkg::ST_PREFIX && walk_ff != cur_ff) begin
         st_addr = SW'(32'(walk_ff) % STATE_ENTRIES);
      end else begin
         st_addr = SW'(32'(cur_ff) % STATE_ENTRIES);
      end
      list_addr = LW'(32'(pos_ff) % EXIT_LIST_ENTRIES);
   end

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (fsm_ff == lasm_pkg::ST_ANIM) begin
         case (req_ff.op)
            lasm_pkg::OP_LOAD_ANIM: begin
               if (32'(req_ff.index) < ANIM_ENTRIES)
                  anim_mem[AW'(req_ff.index)] <= req_ff.load_word[59:0];
            end
            lasm_pkg::OP_LOAD_EXIT: begin
               if (32'(req_ff.index) < EXIT_ENTRIES) begin
                  cond_mem[EW'(req_ff.index)] <= req_ff.load_word[20:0];
                  lim_mem[EW'(req_ff.index)]  <= {req_ff.load_extra, req_ff.load_word[63:21]};
               end
            end
            lasm_pkg::OP_LOAD_ST: begin
               if (32'(req_ff.index) < STATE_ENTRIES)
                  st_mem[SW'(req_ff.index)] <= req_ff.load_word[9:0];
            end
            lasm_pkg::OP_LOAD_LIST: begin
               if (32'(req_ff.index) < EXIT_LIST_ENTRIES)
                  list_mem[LW'(req_ff.index)] <= req_ff.load_word[5:0];
            end
            default: begin
            end
         endcase
      end
      st_rd_ff   <= st_mem[st_addr];
      anim_rd_ff <= anim_mem[AW'(32'(st_rd_ff[3:0]) % ANIM_ENTRIES)];
      list_rd_ff <= list_mem[list_addr];
      cond_rd_ff <= cond_mem[EW'(32'(list_rd_ff) % EXIT_ENTRIES)];
      lim_rd_ff  <= lim_mem[EW'(32'(list_rd_ff) % EXIT_ENTRIES)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= lasm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         frac_ff      <= '0;
         down_ff      <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         frac_ff      <= frac_in;
         down_ff      <= down_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      taken_ff <= taken_in;
      walk_ff  <= walk_in;
      pos_ff   <= pos_in;
      left_ff  <= left_in;
      rd_ph_ff <= rd_ph_in;
   end

   // sequencer
   always_comb begin
      logic [7:0] spd;
      logic [1:0] lp;
      logic [8:0] sum;
      logic [7:0] c0, c1, c;
      logic [16:0] m;
      fsm_in       = fsm_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cur_in       = cur_ff;
      frac_in      = frac_ff;
      down_in      = down_ff;
      taken_in     = taken_ff;
      walk_in      = walk_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      rd_ph_in     = rd_ph_ff;
      spd          = anim_rd_ff[57:50];
      lp           = anim_rd_ff[59:58];
      sum          = 9'(frac_ff) + 9'(spd);
      c0           = '0;
      c1           = '0;
      c            = '0;
      m            = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (fsm_ff)
         lasm_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               req_in   = req_data;
               taken_in = 1'b0;
               rd_ph_in = 1'b0;
               fsm_in   = lasm_pkg::ST_ANIM;
            end
         end
         // load / restart happen here; frames wait in a first read phase for the anim read
         lasm_pkg::ST_ANIM: begin
            if (req_ff.op == lasm_pkg::OP_RESTART) begin
               cur_in  = '0;
               frac_in = '0;
               down_in = 1'b0;
               rd_ph_in = 1'b0;
               fsm_in  = lasm_pkg::ST_COLOUR;
            end else if (req_ff.op == lasm_pkg::OP_FRAME) begin
               if (!rd_ph_ff) begin
                  rd_ph_in = 1'b1;   // st read lands, anim read next
               end else begin
                  // advance the fraction
                  if (lp == lasm_pkg::REPEAT_WRAP) begin
                     frac_in = sum[7:0];
                  end else if (lp == lasm_pkg::REPEAT_BOUNCE) begin
                     if (!down_ff) begin
                        if (frac_ff >= 8'd255 - spd) begin
                           frac_in = 8'd255;
                           down_in = 1'b1;
                        end else begin
                           frac_in = sum[7:0];
                        end
                     end else if (frac_ff <= spd) begin
                        frac_in = 8'd0;
                        down_in = 1'b0;
                     end else begin
                        frac_in = frac_ff - spd;
                     end
                  end else begin
                     frac_in = (frac_ff >= 8'd255 - spd) ? 8'd255 : sum[7:0];
                  end
                  walk_in  = '0;
                  pos_in   = '0;
                  rd_ph_in = 1'b0;
                  fsm_in   = lasm_pkg::ST_PREFIX;
               end
            end else begin
               rd_ph_in = 1'b0;
               fsm_in   = lasm_pkg::ST_COLOUR;
            end
         end
         // sum the exit counts of states below the current one, then load its own count
         lasm_pkg::ST_PREFIX: begin
            if (!rd_ph_ff) begin
               rd_ph_in = 1'b1;
            end else if (walk_ff != cur_ff) begin
               pos_in   = pos_ff + 11'(st_rd_ff[9:4]);
               walk_in  = walk_ff + 4'd1;
               rd_ph_in = 1'b0;
            end else begin
               left_in  = st_rd_ff[9:4];
               rd_ph_in = 1'b0;
               fsm_in   = (st_rd_ff[9:4] == 6'd0) ? lasm_pkg::ST_COLOUR
                                                  : lasm_pkg::ST_LIST;
            end
         end
         lasm_pkg::ST_LIST: fsm_in = lasm_pkg::ST_EXIT;
         lasm_pkg::ST_EXIT: fsm_in = lasm_pkg::ST_TEST;
         // first read phase feeds the checker, second sees its registered pass
         lasm_pkg::ST_TEST: begin
            if (!rd_ph_ff) begin
               rd_ph_in = 1'b1;
            end else begin
               if (pass) begin
                  cur_in   = cond_rd_ff[3:0];
                  frac_in  = '0;
                  down_in  = 1'b0;
                  taken_in = 1'b1;
                  fsm_in   = lasm_pkg::ST_COLOUR;
               end else if (left_ff == 6'd1) begin
                  fsm_in = lasm_pkg::ST_COLOUR;
               end else begin
                  left_in = left_ff - 6'd1;
                  pos_in  = pos_ff + 11'd1;
                  fsm_in  = lasm_pkg::ST_LIST;
               end
               rd_ph_in = 1'b0;
            end
         end
         // wait for the state and anim reads of the final state
         lasm_pkg::ST_COLOUR: begin
            if (!rd_ph_ff) begin
               rd_ph_in = 1'b1;
            end else begin
               rd_ph_in = 1'b0;
               fsm_in   = lasm_pkg::ST_OUT;
            end
         end
         lasm_pkg::ST_OUT: begin
            c0 = anim_rd_ff[7:0];
            c1 = anim_rd_ff[31:24];
            c  = c0;
            m  = 17'(c0) * 17'(9'd256 - 9'(frac_ff));
            if (anim_rd_ff[49:48] == lasm_pkg::METH_BINARY) c = frac_ff[7] ? c1 : c0;
            else if (anim_rd_ff[49:48] == lasm_pkg::METH_LERP)
               c = m[15:8] + 8'((16'(c1) * 16'(frac_ff)) >> 8);
            rsp_in.red = c;
            c0 = anim_rd_ff[15:8];
            c1 = anim_rd_ff[39:32];
            c  = c0;
            m  = 17'(c0) * 17'(9'd256 - 9'(frac_ff));
            if (anim_rd_ff[49:48] == lasm_pkg::METH_BINARY) c = frac_ff[7] ? c1 : c0;
            else if (anim_rd_ff[49:48] == lasm_pkg::METH_LERP)
               c = m[15:8] + 8'((16'(c1) * 16'(frac_ff)) >> 8);
            rsp_in.green = c;
            c0 = anim_rd_ff[23:16];
            c1 = anim_rd_ff[47:40];
            c  = c0;
            m  = 17'(c0) * 17'(9'd256 - 9'(frac_ff));
            if (anim_rd_ff[49:48] == lasm_pkg::METH_BINARY) c = frac_ff[7] ? c1 : c0;
            else if (anim_rd_ff[49:48] == lasm_pkg::METH_LERP)
               c = m[15:8] + 8'((16'(c1) * 16'(frac_ff)) >> 8);
            rsp_in.blue       = c;
            rsp_in.state_now  = cur_ff;
            rsp_in.exit_taken = taken_ff;
            rsp_valid_in      = 1'b1;
            fsm_in            = lasm_pkg::ST_IDLE;
         end
         default: fsm_in = lasm_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `LASM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "accepted while busy")
   `LASM_ASSERT_NOW(a_ready_idle, clock, reset, req_ready, fsm_ff == lasm_pkg::ST_IDLE && !rsp_valid_ff, "ready outside idle")
   `LASM_ASSERT_NEXT(a_out_valid, clock, reset, fsm_ff == lasm_pkg::ST_OUT, rsp_valid, "result not presented")

endmodule
`default_nettype wire

// ===== test/tb_led_animation_state_machine.sv =====
// ----------------------------------------------------------------------------
// tb_led_animation_state_machine
// self-checking bench: fills the animation tables, runs directed corner cases
// and random frame traffic, and compares every response with a predictor
// ----------------------------------------------------------------------------
`default_nettype none

class lasm_scoreboard;

   bit [59:0] anim_mem[16];
   bit        anim_set[16];
   bit [20:0] cond_mem[64];
   bit [52:0] lim_mem[64];
   bit [9:0]  state_mem[16];
   bit        state_set[16];
   bit [5:0]  list_mem[64];
   bit [3:0]  cur_state;
   bit [7:0]  frac;
   bit        bounce_down;

   lasm_pkg::rsp_type colour_q[$];
   bit        known_q[$];
   int        errors;

   task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function bit stick_points(bit [2:0] dir, bit [7:0] x, bit [7:0] y);
      int dx, dy, adx, ady;
      bit neutral;
      dx = int'(x) - lasm_pkg::CENTRE;
      dy = int'(y) - lasm_pkg::CENTRE;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      neutral = (dx * dx + dy * dy) <= lasm_pkg::NEUTRAL_R2;
      case (dir)
         lasm_pkg::DIR_NORTH: return !neutral && dy >= 0 && adx <= dy;
         lasm_pkg::DIR_EAST:  return !neutral && dx >= 0 && ady < dx;
         lasm_pkg::DIR_SOUTH: return !neutral && dy < 0 && adx <= -dy;
         lasm_pkg::DIR_WEST:  return !neutral && dx < 0 && ady < -dx;
         default:             return neutral;
      endcase
   endfunction

   function bit exit_holds(bit [5:0] e, lasm_pkg::req_type r);
      bit [15:0] bmask;
      bit [6:0]  amask;
      bit [52:0] lim;
      int        hits, need;
      lim   = lim_mem[e];
      bmask = cond_mem[e][20:5];
      amask = lim[6:0];
      hits  = $countones(bmask & r.buttons);
      if (amask[0]) hits += stick_points(lim[9:7], r.joy_x, r.joy_y);
      if (amask[1]) hits += stick_points(lim[12:10], r.cstick_x, r.cstick_y);
      if (amask[2]) hits += r.trigger_left > lim[20:13];
      if (amask[3]) hits += r.trigger_left < lim[28:21];
      if (amask[4]) hits += r.trigger_right > lim[36:29];
      if (amask[5]) hits += r.trigger_right < lim[44:37];
      if (amask[6]) hits += frac >= lim[52:45];
      need = $countones(bmask) + $countones(amask);
      if (cond_mem[e][4]) return hits > 0;
      return hits >= need;
   endfunction

   function void step_fraction();
      bit [59:0] a;
      int        f, spd;
      a   = anim_mem[state_mem[cur_state][3:0]];
      spd = a[57:50];
      f   = frac;
      if (a[59:58] == lasm_pkg::REPEAT_WRAP) begin
         f = (f + spd) & 255;
      end else if (a[59:58] == lasm_pkg::REPEAT_BOUNCE) begin
         if (!bounce_down) begin
            if (f >= 255 - spd) begin
               f = 255;
               bounce_down = 1;
            end else f += spd;
         end else begin
            if (f <= spd) begin
               f = 0;
               bounce_down = 0;
            end else f -= spd;
         end
      end else begin
         if (f >= 255 - spd) f = 255;
         else f += spd;
      end
      frac = f[7:0];
   endfunction

   // accepted request: update the model and queue the response it implies
   function void note_request(lasm_pkg::req_type r);
      lasm_pkg::rsp_type exp_rsp;
      bit [59:0] a;
      bit        taken;
      int        pos, n, c0, c1, c, f;
      taken = 0;
      case (r.op)
         lasm_pkg::OP_FRAME: begin
            step_fraction();
            pos = 0;
            for (int i = 0; i < cur_state; i++) pos += state_mem[i][9:4];
            n = state_mem[cur_state][9:4];
            for (int i = 0; i < n; i++) begin
               bit [5:0] e;
               e = list_mem[(pos + i) % 64];
               if (exit_holds(e, r)) begin
                  cur_state = cond_mem[e][3:0];
                  frac = 0;
                  bounce_down = 0;
                  taken = 1;
                  break;
               end
            end
         end
         lasm_pkg::OP_LOAD_ANIM: if (r.index < 16) begin
            anim_mem[r.index] = r.load_word[59:0];
            anim_set[r.index] = 1;
         end
         lasm_pkg::OP_LOAD_EXIT: begin
            cond_mem[r.index] = r.load_word[20:0];
            lim_mem[r.index]  = {r.load_extra, r.load_word[63:21]};
         end
         lasm_pkg::OP_LOAD_ST: if (r.index < 16) begin
            state_mem[r.index] = r.load_word[9:0];
            state_set[r.index] = 1;
         end
         lasm_pkg::OP_LOAD_LIST: list_mem[r.index] = r.load_word[5:0];
         lasm_pkg::OP_RESTART: begin
            cur_state = 0;
            frac = 0;
            bounce_down = 0;
         end
         default: ;
      endcase
      a = anim_mem[state_mem[cur_state][3:0]];
      f = frac;
      for (int k = 0; k < 3; k++) begin
         c0 = a[8*k +: 8];
         c1 = a[24 + 8*k +: 8];
         c  = c0;
         if (a[49:48] == lasm_pkg::METH_BINARY) c = f >= 128 ? c1 : c0;
         else if (a[49:48] == lasm_pkg::METH_LERP)
            c = (((c0 * (256 - f)) >> 8) + ((c1 * f) >> 8)) & 255;
         case (k)
            0: exp_rsp.red = c[7:0];
            1: exp_rsp.green = c[7:0];
            default: exp_rsp.blue = c[7:0];
         endcase
      end
      exp_rsp.state_now  = cur_state;
      exp_rsp.exit_taken = taken;
      colour_q.push_back(exp_rsp);
      // colour is only meaningful once the state and its animation are loaded
      known_q.push_back(state_set[cur_state] && anim_set[state_mem[cur_state][3:0]]);
   endfunction

   task check_response(lasm_pkg::rsp_type got);
      lasm_pkg::rsp_type w;
      bit      known;
      if (colour_q.size() == 0) begin
         report_mismatch("response with nothing outstanding");
         return;
      end
      w = colour_q.pop_front();
      known = known_q.pop_front();
      if (got.state_now != w.state_now)
         report_mismatch($sformatf("state_now %0d, wanted %0d", got.state_now, w.state_now));
      if (got.exit_taken != w.exit_taken)
         report_mismatch($sformatf("exit_taken %0b, wanted %0b", got.exit_taken,
                                   w.exit_taken));
      if (known && got.red != w.red)
         report_mismatch($sformatf("red %0d, wanted %0d", got.red, w.red));
      if (known && got.green != w.green)
         report_mismatch($sformatf("green %0d, wanted %0d", got.green, w.green));
      if (known && got.blue != w.blue)
         report_mismatch($sformatf("blue %0d, wanted %0d", got.blue, w.blue));
   endtask
endclass

module tb_led_animation_state_machine;

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1470;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   lasm_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   lasm_pkg::rsp_type rsp_data;

   lasm_scoreboard colour_board = new();
   bit      quiet_phase;  // stretch with no idling on either side
   int      idle_cycles;
   int      rsp_hold;

   led_animation_state_machine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // mostly short gaps, now and then a long one
   function int gap_length();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // monitor: sample both channels at the edge, before any new drive lands
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) colour_board.check_response(rsp_data);
         if (req_valid && req_ready) colour_board.note_request(req_data);
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1;
         if (rsp_valid && rsp_ready) rsp_hold <= gap_length();
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // present one transaction and hold it until it is taken
   task automatic send(lasm_pkg::req_type item);
      int g;
      req_valid <= 1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      g = gap_length();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic lasm_pkg::req_type make_req(logic [2:0] op, logic [5:0] idx,
                                                  logic [63:0] word, logic [9:0] extra);
      lasm_pkg::req_type r;
      r.op = op;
      r.index = idx;
      r.load_word = word;
      r.load_extra = extra;
      r.buttons = 16'($urandom);
      // half of the frames keep the sticks close to the neutral circle
      if ($urandom_range(0, 1)) begin
         r.joy_x    = 8'($urandom_range(118, 136));
         r.joy_y    = 8'($urandom_range(118, 136));
         r.cstick_x = 8'($urandom_range(118, 136));
         r.cstick_y = 8'($urandom_range(118, 136));
      end else begin
         r.joy_x    = 8'($urandom);
         r.joy_y    = 8'($urandom);
         r.cstick_x = 8'($urandom);
         r.cstick_y = 8'($urandom);
      end
      r.trigger_left  = 8'($urandom);
      r.trigger_right = 8'($urandom);
      return r;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // exit entry: mostly any-mode with a few sparse conditions so exits fire
   task automatic load_exit(logic [5:0] idx);
      logic [63:0] w;
      logic [9:0]  x;
      w = rand_word();
      x = 10'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         w[4] = 1;
         w[20:5] = $urandom_range(0, 3) == 0 ? 16'h0 : 16'(1 << $urandom_range(0, 15));
         w[27:21] = 7'($urandom) & 7'($urandom);
      end
      send(make_req(lasm_pkg::OP_LOAD_EXIT, idx, w, x));
   endtask

   // state entry: short exit lists mostly, occasionally a long one
   task automatic load_state(logic [5:0] idx);
      logic [63:0] w;
      w = rand_word();
      if ($urandom_range(0, 9) != 0) w[9:4] = 6'($urandom_range(0, 4));
      send(make_req(lasm_pkg::OP_LOAD_ST, idx, w, 10'($urandom)));
   endtask

   initial begin
      logic [63:0] w;
      int          r;
      quiet_phase = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill every table before the first frame
      for (int i = 0; i < 16; i++) load_state(6'(i));
      for (int i = 0; i < 16; i++) begin
         w = rand_word();
         w[49:48] = 2'(i);
         w[59:58] = 2'(i >> 2);
         send(make_req(lasm_pkg::OP_LOAD_ANIM, 6'(i), w, 10'($urandom)));
      end
      for (int i = 0; i < 64; i++) load_exit(6'(i));
      for (int i = 0; i < 64; i++)
         send(make_req(lasm_pkg::OP_LOAD_LIST, 6'(i), rand_word(), 10'($urandom)));

      // directed corners: speed extremes, every op, ignored loads, spare ops
      send(make_req(lasm_pkg::OP_LOAD_ANIM, 6'd0,
                    {4'h0, 2'd2, 8'hff, 2'd2, 48'hffffff_000000}, '0));
      send(make_req(lasm_pkg::OP_LOAD_ANIM, 6'd1,
                    {4'h0, 2'd1, 8'h00, 2'd1, 48'h000000_ffffff}, '1));
      send(make_req(lasm_pkg::OP_LOAD_ANIM, 6'd2,
                    {4'hf, 2'd0, 8'h01, 2'd0, 48'h123456_abcdef}, '0));
      send(make_req(lasm_pkg::OP_LOAD_ANIM, 6'd20, '1, '1));
      send(make_req(lasm_pkg::OP_LOAD_ST, 6'd63, '1, '1));
      send(make_req(lasm_pkg::OP_LOAD_EXIT, 6'd63, '1, '1));
      send(make_req(lasm_pkg::OP_LOAD_EXIT, 6'd62, '0, '0));
      send(make_req(lasm_pkg::OP_LOAD_LIST, 6'd63, '1, '1));
      send(make_req(lasm_pkg::OP_LOAD_ST, 6'd0, 64'h0000_0000_0000_0000, '0));
      repeat (4) send(make_req(lasm_pkg::OP_FRAME, '0, '0, '0));
      send(make_req(lasm_pkg::OP_LOAD_ST, 6'd0, 64'h0000_0000_0000_0021, '0));
      repeat (4) send(make_req(lasm_pkg::OP_FRAME, '1, '1, '1));
      send(make_req(OP_SPARE_6, '1, '1, '1));
      send(make_req(OP_SPARE_7, '0, '0, '0));
      send(make_req(lasm_pkg::OP_RESTART, '0, '0, '0));
      send(make_req(lasm_pkg::OP_FRAME, '0, '0, '0));

      // random traffic: mostly frames with table rewrites and restarts mixed in
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 70)
            send(make_req(lasm_pkg::OP_FRAME, 6'($urandom), rand_word(), 10'($urandom)));
         else if (r < 76)
            send(make_req(lasm_pkg::OP_LOAD_ANIM, 6'($urandom), rand_word(),
                          10'($urandom)));
         else if (r < 83) load_exit(6'($urandom));
         else if (r < 88) load_state(6'($urandom));
         else if (r < 94)
            send(make_req(lasm_pkg::OP_LOAD_LIST, 6'($urandom), rand_word(),
                          10'($urandom)));
         else if (r < 98)
            send(make_req(lasm_pkg::OP_RESTART, 6'($urandom), rand_word(),
                          10'($urandom)));
         else send(make_req($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                            6'($urandom), rand_word(), 10'($urandom)));
      end
      req_valid <= 0;

      // drain outstanding responses; the watchdog bounds this wait
      while (colour_board.colour_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (colour_board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
